[rtl/core/ppr_pkg.sv]
package ppr_pkg;

  localparam int COORD_W = 25;
  localparam int YAW_W = 16;
  localparam int GUARD_BITS = 6;
  localparam int XW = COORD_W + GUARD_BITS + 2;
  localparam int ZW = 32;
  localparam int TABLE_LEN = 30;
  localparam int DEFAULT_ROTATION_STAGES = 16;
  localparam int GAIN_W = 32;
  localparam int PW = XW + GAIN_W;
  localparam int ROUND_SHIFT = 31 + GUARD_BITS;
  localparam int RW = PW - ROUND_SHIFT;

  localparam logic signed [GAIN_W-1:0] INV_GAIN = 32'sd1304065748;
  localparam logic signed [PW-1:0] ROUND_BIAS = PW'(64'sd1 <<< (ROUND_SHIFT - 1));
  localparam logic signed [RW-1:0] OUT_MAX = RW'(24'h7F_FFFF) | RW'(25'h080_0000);
  localparam logic signed [RW-1:0] OUT_MIN = -OUT_MAX - RW'(1);
  localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sh4000_0000;
  localparam logic signed [YAW_W-1:0] QUARTER_YAW = 16'sh4000;

  localparam logic [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BF, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cell_data_t;

  function automatic cell_data_t pre_rotate(
    input logic signed [COORD_W-1:0] px,
    input logic signed [COORD_W-1:0] py,
    input logic signed [YAW_W-1:0] yaw
  );
    cell_data_t d;
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    logic signed [ZW-1:0] ze;
    xe = {{(XW-COORD_W-GUARD_BITS){px[COORD_W-1]}}, px, {GUARD_BITS{1'b0}}};
    ye = {{(XW-COORD_W-GUARD_BITS){py[COORD_W-1]}}, py, {GUARD_BITS{1'b0}}};
    ze = {yaw, {(ZW-YAW_W){1'b0}}};
    if (yaw > QUARTER_YAW) begin
      d.x = -ye;
      d.y = xe;
      d.z = ze - QUARTER_TURN;
    end else if (yaw < -QUARTER_YAW) begin
      d.x = ye;
      d.y = -xe;
      d.z = ze + QUARTER_TURN;
    end else begin
      d.x = xe;
      d.y = ye;
      d.z = ze;
    end
    return d;
  endfunction

endpackage

[rtl/core/ppr_in_if.sv]
interface ppr_in_if;
  logic valid;
  logic ready;
  logic signed [24:0] point_x;
  logic signed [24:0] point_y;
  logic signed [15:0] yaw_angle;

  modport source (output valid, point_x, point_y, yaw_angle, input ready);
  modport sink (input valid, point_x, point_y, yaw_angle, output ready);
endinterface

[rtl/core/ppr_out_if.sv]
interface ppr_out_if;
  logic valid;
  logic ready;
  logic signed [24:0] rotated_x;
  logic signed [24:0] rotated_y;
  logic clipped;

  modport source (output valid, rotated_x, rotated_y, clipped, input ready);
  modport sink (input valid, rotated_x, rotated_y, clipped, output ready);
endinterface

[rtl/core/ppr_cell.sv]
module ppr_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  ppr_pkg::cell_data_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output ppr_pkg::cell_data_t data_o
);
  import ppr_pkg::*;

  logic       valid_r;
  cell_data_t data_r;
  cell_data_t data_nxt;
  logic       adv;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] step_angle;

  assign adv = !valid_r || ready_i;
  assign ready_o = adv;
  assign dx = data_i.y >>> STAGE;
  assign dy = data_i.x >>> STAGE;
  assign step_angle = $signed(ATAN_TABLE[STAGE]);

  always_comb begin
    if (!data_i.z[ZW-1]) begin
      data_nxt.x = data_i.x - dx;
      data_nxt.y = data_i.y + dy;
      data_nxt.z = data_i.z - step_angle;
    end else begin
      data_nxt.x = data_i.x + dx;
      data_nxt.y = data_i.y - dy;
      data_nxt.z = data_i.z + step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o = data_r;

`ifndef NO_ASSERTIONS
  a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ready_i |=> valid_r && $stable(data_r))
    else $error("ppr_cell: stalled word changed");
`endif

endmodule

[rtl/core/ppr_finish.sv]
module ppr_finish (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  ppr_pkg::cell_data_t data_i,
  ppr_out_if.source           out_ch
);
  import ppr_pkg::*;

  logic                 prod_valid_r;
  logic signed [PW-1:0] prod_x_r;
  logic signed [PW-1:0] prod_y_r;
  logic                 out_valid_r;
  logic signed [COORD_W-1:0] rot_x_r;
  logic signed [COORD_W-1:0] rot_y_r;
  logic                 clip_r;
  logic                 adv_prod;
  logic                 adv_out;
  logic signed [PW-1:0] sum_x;
  logic signed [PW-1:0] sum_y;
  logic signed [RW-1:0] round_x;
  logic signed [RW-1:0] round_y;
  logic signed [COORD_W-1:0] rot_x_nxt;
  logic signed [COORD_W-1:0] rot_y_nxt;
  logic                 clip_x;
  logic                 clip_y;

  assign adv_out = !out_valid_r || out_ch.ready;
  assign adv_prod = !prod_valid_r || adv_out;
  assign ready_o = adv_prod;

  assign sum_x = prod_x_r + ROUND_BIAS;
  assign sum_y = prod_y_r + ROUND_BIAS;
  assign round_x = sum_x[PW-1:ROUND_SHIFT];
  assign round_y = sum_y[PW-1:ROUND_SHIFT];

  always_comb begin
    clip_x = 1'b1;
    clip_y = 1'b1;
    if (round_x > OUT_MAX) begin
      rot_x_nxt = OUT_MAX[COORD_W-1:0];
    end else if (round_x < OUT_MIN) begin
      rot_x_nxt = OUT_MIN[COORD_W-1:0];
    end else begin
      rot_x_nxt = round_x[COORD_W-1:0];
      clip_x = 1'b0;
    end
    if (round_y > OUT_MAX) begin
      rot_y_nxt = OUT_MAX[COORD_W-1:0];
    end else if (round_y < OUT_MIN) begin
      rot_y_nxt = OUT_MIN[COORD_W-1:0];
    end else begin
      rot_y_nxt = round_y[COORD_W-1:0];
      clip_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_prod) begin
        prod_valid_r <= valid_i;
      end
      if (adv_out) begin
        out_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_prod && valid_i) begin
      prod_x_r <= PW'(data_i.x) * PW'(INV_GAIN);
      prod_y_r <= PW'(data_i.y) * PW'(INV_GAIN);
    end
    if (adv_out && prod_valid_r) begin
      rot_x_r <= rot_x_nxt;
      rot_y_r <= rot_y_nxt;
      clip_r <= clip_x || clip_y;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.rotated_x = rot_x_r;
  assign out_ch.rotated_y = rot_y_r;
  assign out_ch.clipped = clip_r;

`ifndef NO_ASSERTIONS
  a_fin_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && clip_r |->
      (rot_x_r == OUT_MAX[COORD_W-1:0]) || (rot_x_r == OUT_MIN[COORD_W-1:0]) ||
      (rot_y_r == OUT_MAX[COORD_W-1:0]) || (rot_y_r == OUT_MIN[COORD_W-1:0]))
    else $error("ppr_finish: clipped word not at a bound");
`endif

endmodule

[rtl/core/planar_point_rotation_core.sv]
// Throughput: one word per cycle while out_ch.ready does not stall the output; an
// accepted word passes a chain of rotation cells, then a gain multiply stage and a
// rounding and saturation stage, each holding one word.
// Reset: synchronous, active low; it clears every valid flag, data registers keep
// their contents.
module planar_point_rotation_core #(
  parameter int ROTATION_STAGES = ppr_pkg::DEFAULT_ROTATION_STAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  ppr_in_if.sink     in_ch,
  ppr_out_if.source  out_ch
);
  import ppr_pkg::*;

  logic       chain_valid [ROTATION_STAGES+1];
  logic       chain_ready [ROTATION_STAGES+1];
  cell_data_t chain_data  [ROTATION_STAGES+1];

  assign chain_valid[0] = in_ch.valid;
  assign in_ch.ready = chain_ready[0];
  assign chain_data[0] = pre_rotate(in_ch.point_x, in_ch.point_y, in_ch.yaw_angle);

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
    ppr_cell #(
      .STAGE (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  ppr_finish u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (chain_valid[ROTATION_STAGES]),
    .ready_o (chain_ready[ROTATION_STAGES]),
    .data_i  (chain_data[ROTATION_STAGES]),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_top_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("core: input stalled while output is empty");
  a_top_ready_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("core: input stalled while output is being taken");
`endif

endmodule
